FILE: rtl/core/ltri_pkg.sv
// shared types and constants for the line-triangle intersection pipeline
package ltri_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_WIDTH     = 48;
  localparam int DET_MIN_WIDTH   = 54;
  localparam int TIME_WIDTH      = 32;
  localparam int FRAC_SHIFT      = 16;
  localparam int DET_MIN_RESET   = 168;

  // configuration register indexes
  localparam logic CFG_ACCEPT_BACKFACE = 1'b0;
  localparam logic CFG_DET_MIN         = 1'b1;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic hit;
    logic neg;
    logic big;
  } ltri_ctl_t;

endpackage

FILE: rtl/core/ltri_front.sv
// geometry stages: edge vectors, cross and dot products, hit tests
module ltri_front import ltri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [3*COORD_WIDTH-1:0]        va,
  input  logic [3*COORD_WIDTH-1:0]        vb,
  input  logic [3*COORD_WIDTH-1:0]        vc,
  input  logic [3*COORD_WIDTH-1:0]        vl1,
  input  logic [3*COORD_WIDTH-1:0]        vl2,
  input  logic                            accept_backface,
  input  logic [DET_MIN_WIDTH-1:0]        det_min,
  output logic                            out_valid,
  output ltri_ctl_t                       out_ctl,
  output logic [3*COORD_WIDTH+7:0]        out_dabs,
  output logic [3*COORD_WIDTH+39:0]       out_rem,
  output logic signed [COORD_WIDTH:0]     out_d [3],
  output logic signed [COORD_WIDTH-1:0]   out_l1 [3]
);

  localparam int W   = COORD_WIDTH;
  localparam int DIF = W + 1;
  localparam int PW  = 2 * DIF;
  localparam int XW  = PW + 1;
  localparam int QW  = DIF + XW;
  localparam int DW  = 3 * W + 8;
  localparam int RW  = DW + 32;
  localparam int CW  = (DW > DET_MIN_WIDTH) ? DW + 1 : DET_MIN_WIDTH + 1;

  logic [5:0] v;

  logic signed [DIF-1:0] e1_1 [3], e2_1 [3], d_1 [3], s_1 [3];
  logic signed [W-1:0]   l1_1 [3], l1_2 [3], l1_3 [3], l1_4 [3], l1_5 [3];
  logic signed [DIF-1:0] e1_2 [3], e2_2 [3], d_2 [3], s_2 [3];
  logic signed [DIF-1:0] e1_3 [3], e2_3 [3], d_3 [3], s_3 [3];
  logic signed [DIF-1:0] d_4 [3], d_5 [3];
  logic signed [PW-1:0]  pa [3], pb [3], qa [3], qb [3];
  logic signed [XW-1:0]  p [3], q [3];
  logic signed [QW-1:0]  pdet [3], punum [3], pvnum [3], ptnum [3];
  logic signed [DW-1:0]  det, unum, vnum, tnum;

  // stage 6 combinational tests
  logic                  det_neg, miss;
  logic signed [DW-1:0]  dabs, un, vn, uvs, tabs;
  logic [RW-1:0]         m, dsh;

  always_comb begin
    det_neg = det[DW-1];
    dabs    = det_neg ? -det : det;
    un      = det_neg ? -unum : unum;
    vn      = det_neg ? -vnum : vnum;
    uvs     = un + vn;
    tabs    = tnum[DW-1] ? -tnum : tnum;
    m       = RW'(unsigned'(tabs)) << FRAC_SHIFT;
    dsh     = RW'(unsigned'(dabs)) << 32;
    miss    = (det == '0)
           || (CW'(unsigned'(dabs)) < CW'(det_min))
           || un[DW-1] || (un > dabs)
           || vn[DW-1] || (uvs > dabs)
           || (!accept_backface && (tnum[DW-1] || tnum == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_1[k] <= $signed({vb[k*W+W-1], vb[k*W +: W]}) - $signed({va[k*W+W-1], va[k*W +: W]});
        e2_1[k] <= $signed({vc[k*W+W-1], vc[k*W +: W]}) - $signed({va[k*W+W-1], va[k*W +: W]});
        d_1[k]  <= $signed({vl2[k*W+W-1], vl2[k*W +: W]})
                 - $signed({vl1[k*W+W-1], vl1[k*W +: W]});
        s_1[k]  <= $signed({vl1[k*W+W-1], vl1[k*W +: W]}) - $signed({va[k*W+W-1], va[k*W +: W]});
        l1_1[k] <= $signed(vl1[k*W +: W]);

        // cross product terms: p = d x e2, q = s x e1
        pa[k] <= PW'(d_1[(k+1)%3]) * PW'(e2_1[(k+2)%3]);
        pb[k] <= PW'(d_1[(k+2)%3]) * PW'(e2_1[(k+1)%3]);
        qa[k] <= PW'(s_1[(k+1)%3]) * PW'(e1_1[(k+2)%3]);
        qb[k] <= PW'(s_1[(k+2)%3]) * PW'(e1_1[(k+1)%3]);
        e1_2[k] <= e1_1[k]; e2_2[k] <= e2_1[k]; d_2[k] <= d_1[k]; s_2[k] <= s_1[k];
        l1_2[k] <= l1_1[k];

        p[k] <= XW'(pa[k]) - XW'(pb[k]);
        q[k] <= XW'(qa[k]) - XW'(qb[k]);
        e1_3[k] <= e1_2[k]; e2_3[k] <= e2_2[k]; d_3[k] <= d_2[k]; s_3[k] <= s_2[k];
        l1_3[k] <= l1_2[k];

        pdet[k]  <= QW'(e1_3[k]) * QW'(p[k]);
        punum[k] <= QW'(s_3[k]) * QW'(p[k]);
        pvnum[k] <= QW'(d_3[k]) * QW'(q[k]);
        ptnum[k] <= QW'(e2_3[k]) * QW'(q[k]);
        d_4[k]  <= d_3[k];
        l1_4[k] <= l1_3[k];

        d_5[k]  <= d_4[k];
        l1_5[k] <= l1_4[k];

        out_d[k]  <= d_5[k];
        out_l1[k] <= l1_5[k];
      end
      det  <= DW'(pdet[0]) + DW'(pdet[1]) + DW'(pdet[2]);
      unum <= DW'(punum[0]) + DW'(punum[1]) + DW'(punum[2]);
      vnum <= DW'(pvnum[0]) + DW'(pvnum[1]) + DW'(pvnum[2]);
      tnum <= DW'(ptnum[0]) + DW'(ptnum[1]) + DW'(ptnum[2]);

      out_ctl.hit <= !miss;
      out_ctl.neg <= tnum[DW-1] ^ det_neg;
      out_ctl.big <= (m >= dsh);
      out_dabs    <= unsigned'(dabs);
      out_rem     <= m;
    end
  end

  assign out_valid = v[5];

endmodule

FILE: rtl/core/ltri_div.sv
// restoring divider for the line parameter, one quotient bit per stage
module ltri_div import ltri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  ltri_ctl_t                       in_ctl,
  input  logic [3*COORD_WIDTH+7:0]        in_dabs,
  input  logic [3*COORD_WIDTH+39:0]       in_rem,
  input  logic signed [COORD_WIDTH:0]     in_d [3],
  input  logic signed [COORD_WIDTH-1:0]   in_l1 [3],
  output logic                            out_valid,
  output ltri_ctl_t                       out_ctl,
  output logic [TIME_WIDTH-1:0]           out_quot,
  output logic signed [COORD_WIDTH:0]     out_d [3],
  output logic signed [COORD_WIDTH-1:0]   out_l1 [3]
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 3 * W + 8;
  localparam int RW = DW + 32;
  localparam int NS = TIME_WIDTH;

  logic                  v    [NS+1];
  ltri_ctl_t             ctl  [NS+1];
  logic [DW-1:0]         dabs [NS+1];
  logic [RW-1:0]         rem  [NS+1];
  logic [NS-1:0]         quot [NS+1];
  logic signed [W:0]     d    [NS+1][3];
  logic signed [W-1:0]   l1   [NS+1][3];

  assign v[0]    = in_valid;
  assign ctl[0]  = in_ctl;
  assign dabs[0] = in_dabs;
  assign rem[0]  = in_rem;
  assign quot[0] = '0;
  assign d[0]    = in_d;
  assign l1[0]   = in_l1;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int BIT = NS - 1 - g;
    logic [RW-1:0] sh;
    logic          take;

    assign sh   = RW'(dabs[g]) << BIT;
    assign take = !ctl[g].big && (rem[g] >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[g+1]  <= ctl[g];
        dabs[g+1] <= dabs[g];
        rem[g+1]  <= take ? rem[g] - sh : rem[g];
        quot[g+1] <= quot[g] | (NS'(take) << BIT);
        d[g+1]    <= d[g];
        l1[g+1]   <= l1[g];
      end
    end
  end

  assign out_valid = v[NS];
  assign out_ctl   = ctl[NS];
  assign out_quot  = quot[NS];
  assign out_d     = d[NS];
  assign out_l1    = l1[NS];

  // an overflowing quotient is never developed
  a_big_no_quot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ctl.big |-> out_quot == '0)
    else $error("quotient bits set on overflow");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ctl.big |-> rem[NS] < RW'(dabs[NS]) || dabs[NS] == '0)
    else $error("remainder not below divisor");

  a_valid_flow: assert property (@(posedge clk) disable iff (rst)
    en && v[NS-1] |=> out_valid)
    else $error("valid lost in divider");

endmodule

FILE: rtl/core/ltri_back.sv
// t saturation, hit point and output register
module ltri_back import ltri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  ltri_ctl_t                       in_ctl,
  input  logic [TIME_WIDTH-1:0]           in_quot,
  input  logic signed [COORD_WIDTH:0]     in_d [3],
  input  logic signed [COORD_WIDTH-1:0]   in_l1 [3],
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [TIME_WIDTH-1:0]           out_time,
  output logic [3*COORD_WIDTH-1:0]        out_point
);

  localparam int W   = COORD_WIDTH;
  localparam int MW  = W + 1 + TIME_WIDTH;
  localparam int SW  = MW - FRAC_SHIFT;
  localparam int AW  = SW + 1;
  localparam logic [TIME_WIDTH-1:0] T_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic [TIME_WIDTH-1:0] T_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

  logic [1:0]                    v;
  logic [1:0]                    hit;
  logic signed [TIME_WIDTH-1:0]  t1, t2;
  logic signed [W:0]             d1 [3];
  logic signed [W-1:0]           l1_1 [3], l1_2 [3];
  logic signed [MW-1:0]          prod [3];
  logic [3*W-1:0]                point;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [AW-1:0] pt;
      pt = AW'(l1_2[k]) + AW'(prod[k] >>> FRAC_SHIFT);
      if (pt > AW'($signed({1'b0, {(W-1){1'b1}}}))) begin
        point[k*W +: W] = {1'b0, {(W-1){1'b1}}};
      end else if (pt < AW'($signed({1'b1, {(W-1){1'b0}}}))) begin
        point[k*W +: W] = {1'b1, {(W-1){1'b0}}};
      end else begin
        point[k*W +: W] = pt[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[0], in_valid};
      out_valid <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= {hit[0], in_ctl.hit};
      if (!in_ctl.neg) begin
        t1 <= (in_ctl.big || in_quot[TIME_WIDTH-1]) ? T_MAX : in_quot;
      end else begin
        t1 <= (in_ctl.big || in_quot > T_MIN) ? T_MIN : -in_quot;
      end
      d1   <= in_d;
      l1_1 <= in_l1;

      for (int k = 0; k < 3; k++) begin
        prod[k] <= MW'(d1[k]) * MW'(t1);
      end
      t2   <= t1;
      l1_2 <= l1_1;

      out_hit   <= hit[1];
      out_time  <= hit[1] ? t2 : '0;
      out_point <= hit[1] ? point : '0;
    end
  end

endmodule

FILE: rtl/core/line_triangle_intersect.sv
// line-triangle intersection pipeline
// throughput one item per cycle while the output is not stalled; the 32-stage restoring divider for t sets the depth
// 6 geometry stages, 32 divider stages, 3 stages for t, hit point and output register
// a stall at the output holds every stage; nothing is lost or repeated
// rst clears all valid bits, accept_backface to 0 and det_min to 168
module line_triangle_intersect import ltri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // vertex_a, vertex_b, vertex_c, line_start, line_end (48 bits each)
  input  logic [239:0]             s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // hit, hit_time[31:0], hit_point[47:0], 7 zero bits
  output logic [87:0]              m_tdata,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [DET_MIN_WIDTH-1:0] cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int PK = 3 * W;

  logic                     accept_backface;
  logic [DET_MIN_WIDTH-1:0] det_min;
  logic                     adv;
  logic [PK-1:0]            vin [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      accept_backface <= 1'b0;
      det_min         <= DET_MIN_WIDTH'(DET_MIN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEPT_BACKFACE: accept_backface <= cfg_data[0];
        CFG_DET_MIN:         det_min <= cfg_data;
        default:             ;
      endcase
    end
  end

  for (genvar i = 0; i < 5; i++) begin : g_unpack
    if (PK > FIELD_WIDTH) begin : g_ext
      assign vin[i] = {{(PK-FIELD_WIDTH){1'b0}}, s_tdata[i*FIELD_WIDTH +: FIELD_WIDTH]};
    end else begin : g_cut
      assign vin[i] = s_tdata[i*FIELD_WIDTH +: PK];
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic                 f_valid;
  ltri_ctl_t            f_ctl;
  logic [3*W+7:0]       f_dabs;
  logic [3*W+39:0]      f_rem;
  logic signed [W:0]    f_d [3];
  logic signed [W-1:0]  f_l1 [3];

  ltri_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .en(adv), .in_valid(s_tvalid),
    .va(vin[0]), .vb(vin[1]), .vc(vin[2]), .vl1(vin[3]), .vl2(vin[4]),
    .accept_backface, .det_min,
    .out_valid(f_valid), .out_ctl(f_ctl), .out_dabs(f_dabs), .out_rem(f_rem),
    .out_d(f_d), .out_l1(f_l1)
  );

  logic                  q_valid;
  ltri_ctl_t             q_ctl;
  logic [TIME_WIDTH-1:0] q_quot;
  logic signed [W:0]     q_d [3];
  logic signed [W-1:0]   q_l1 [3];

  ltri_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk, .rst, .en(adv), .in_valid(f_valid), .in_ctl(f_ctl), .in_dabs(f_dabs),
    .in_rem(f_rem), .in_d(f_d), .in_l1(f_l1),
    .out_valid(q_valid), .out_ctl(q_ctl), .out_quot(q_quot), .out_d(q_d), .out_l1(q_l1)
  );

  logic                  o_hit;
  logic [TIME_WIDTH-1:0] o_time;
  logic [PK-1:0]         o_point;
  logic [FIELD_WIDTH-1:0] point48;

  ltri_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .en(adv), .in_valid(q_valid), .in_ctl(q_ctl), .in_quot(q_quot),
    .in_d(q_d), .in_l1(q_l1),
    .out_valid(m_tvalid), .out_hit(o_hit), .out_time(o_time), .out_point(o_point)
  );

  if (PK >= FIELD_WIDTH) begin : g_pt_cut
    assign point48 = o_point[FIELD_WIDTH-1:0];
  end else begin : g_pt_ext
    assign point48 = {{(FIELD_WIDTH-PK){1'b0}}, o_point};
  end

  assign m_tdata = {7'b0, point48, o_time, o_hit};

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[80:1] == '0)
    else $error("miss carries nonzero payload");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the line-triangle intersection pipeline
`timescale 1ns / 1ps

module testbench;
  import ltri_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int LATENCY = 41;
  localparam int N_RANDOM = 1200;
  localparam int HOLD_LEN = 150;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [47:0] pt;
  } isect_t;

  typedef struct {
    logic [47:0] a, b, c, l1, l2;
    logic        chk;
    isect_t      want;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [239:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [87:0] m_tdata;
  logic cfg_we = 0;
  logic cfg_index = CFG_ACCEPT_BACKFACE;
  logic [DET_MIN_WIDTH-1:0] cfg_data = '0;

  line_triangle_intersect u_top (.*);

  initial forever #2 clk = ~clk;

  // local copy of the registers
  logic        backface_ok;
  logic [53:0] det_floor;

  isect_t isect_q[$];
  int     n_fail = 0;
  int     send_idle_pct = 23;
  int     recv_idle_pct = 45;
  int     hold_cycles = 0;
  logic   hold_req = 1'b0;
  logic   hold_done = 1'b0;
  longint cycle = 0;

  function automatic logic signed [16:0] coord(logic [47:0] w, int k);
    logic signed [15:0] v;
    v = w[k*CW +: CW];
    return v;
  endfunction

  function automatic isect_t predict_isect(logic [47:0] va, vb, vc, l1w, l2w);
    longint e1[3], e2[3], d[3], s[3], p[3], q[3], l1[3];
    logic signed [127:0] det, un, vn, tn, dabs, m, rem, sh;
    logic [31:0] qt;
    longint t, prod, shv, ptv;
    logic neg, big;
    isect_t r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      l1[k] = coord(l1w, k);
      e1[k] = coord(vb, k) - coord(va, k);
      e2[k] = coord(vc, k) - coord(va, k);
      d[k]  = coord(l2w, k) - l1[k];
      s[k]  = l1[k] - coord(va, k);
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = 128'(e1[0])*p[0] + 128'(e1[1])*p[1] + 128'(e1[2])*p[2];
    dabs = det < 0 ? -det : det;
    if (det == 0 || dabs < $signed({74'd0, det_floor})) return r;
    un = 128'(s[0])*p[0] + 128'(s[1])*p[1] + 128'(s[2])*p[2];
    vn = 128'(d[0])*q[0] + 128'(d[1])*q[1] + 128'(d[2])*q[2];
    tn = 128'(e2[0])*q[0] + 128'(e2[1])*q[1] + 128'(e2[2])*q[2];
    if (det < 0) begin
      un = -un;
      vn = -vn;
    end
    if (un < 0 || un > dabs) return r;
    if (vn < 0 || un + vn > dabs) return r;
    if (!backface_ok && tn <= 0) return r;
    neg = (tn < 0) != (det < 0);
    m = (tn < 0 ? -tn : tn) <<< 16;
    big = m >= (dabs <<< 32);
    qt = 0;
    if (!big) begin
      rem = m;
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
        sh = dabs <<< bit_i;
        if (rem >= sh) begin
          rem -= sh;
          qt[bit_i] = 1'b1;
        end
      end
    end
    if (!neg) t = (big || qt > 32'h7fffffff) ? 64'sh7fffffff : longint'(qt);
    else t = (big || qt > 32'h80000000) ? -64'sh80000000 : -longint'(qt);
    r.hit = 1'b1;
    r.t = t[31:0];
    for (int k = 0; k < 3; k++) begin
      prod = d[k] * t;
      shv = prod >>> 16;  // floor
      ptv = l1[k] + shv;
      if (ptv > 32767) ptv = 32767;
      if (ptv < -32768) ptv = -32768;
      r.pt[k*CW +: CW] = ptv[15:0];
    end
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [53:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ACCEPT_BACKFACE) backface_ok = val[0];
    else det_floor = val;
  endtask

  task automatic send_triangle(logic [47:0] va, vb, vc, l1, l2, logic chk, isect_t want);
    isect_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {l2, l1, vc, vb, va};
    exp_r = predict_isect(va, vb, vc, l1, l2);
    if (chk && exp_r !== want) begin
      // a typed-in row disagreeing with the predictor is a testbench error
      n_fail++;
      if (n_fail <= 10) $display("table row mismatch: want %h model %h", want, exp_r);
    end
    isect_q.push_back(exp_r);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (isect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [47:0] vec(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [47:0] rnd_small();
    return vec($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
               $urandom_range(0, 2048) - 1024);
  endfunction

  function automatic logic [47:0] rnd_word();
    return 48'({$urandom, $urandom});
  endfunction

  // receiver side
  always @(posedge clk) begin
    isect_t got, exp_r;
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.hit = m_tdata[0];
      got.t   = m_tdata[32:1];
      got.pt  = m_tdata[80:33];
      if (isect_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = isect_q.pop_front();
        if (got !== exp_r || m_tdata[87:81] !== '0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: hit %b/%b t %h/%h pt %h/%h", exp_r.hit, got.hit,
                     exp_r.t, got.t, exp_r.pt, got.pt);
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long back-pressure so the pipeline fills and stalls its input
      hold_cycles <= HOLD_LEN;
      hold_done <= 1'b1;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  dir_row_t rows[$];

  initial begin
    logic [47:0] va, vb, vc, l1, l2;
    backface_ok = 1'b0;
    det_floor = DET_MIN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // triangle in z=0 plane, line along z
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(64,64,256), vec(64,64,0),
                     1, '{1'b1, 32'h10000, vec(64,64,0)}});
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(64,64,-256), vec(64,64,0),
                     1, '{1'b0, 32'h0, 48'h0}});  // back side
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(0,0,256), vec(0,0,0),
                     0, '0});  // vertex hit
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(128,128,256),
                     vec(128,128,0), 0, '0});  // on edge u+v=1
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(300,0,256), vec(300,0,0),
                     1, '{1'b0, 32'h0, 48'h0}});  // u > 1
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(-10,10,256), vec(-10,10,0),
                     1, '{1'b0, 32'h0, 48'h0}});  // u < 0
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(0,0,256), vec(256,0,256),
                     1, '{1'b0, 32'h0, 48'h0}});  // parallel line
    rows.push_back('{vec(0,0,0), vec(0,0,0), vec(0,0,0), vec(0,0,1), vec(0,0,0),
                     1, '{1'b0, 32'h0, 48'h0}});  // degenerate
    rows.push_back('{vec(0,0,0), vec(1,0,0), vec(0,1,0), vec(0,0,5), vec(0,0,4),
                     0, '0});  // det tiny
    rows.push_back('{vec(0,0,0), vec(256,0,0), vec(0,256,0), vec(64,64,512), vec(64,64,768),
                     0, '0});  // negative t
    rows.push_back('{vec(-32768,-32768,0), vec(32767,-32768,0), vec(-32768,32767,0),
                     vec(0,0,32767), vec(0,0,32766), 0, '0});  // huge t, saturation
    rows.push_back('{vec(-32768,-32768,-32768), vec(32767,32767,32767), vec(32767,-32768,0),
                     vec(32767,32767,-32768), vec(-32768,-32768,32767), 0, '0});
    rows.push_back('{48'hffffffffffff, 48'h0, 48'hffff0000ffff, 48'h7fff8000ffff,
                     48'h80007fff0000, 0, '0});

    foreach (rows[i])
      send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].l1, rows[i].l2,
                    rows[i].chk, rows[i].want);
    drain();
    write_reg(CFG_ACCEPT_BACKFACE, 1);
    write_reg(CFG_DET_MIN, 0);
    foreach (rows[i]) send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].l1,
                                    rows[i].l2, 0, '0);
    drain();
    write_reg(CFG_DET_MIN, {DET_MIN_WIDTH{1'b1}});
    foreach (rows[i]) send_triangle(rows[i].a, rows[i].b, rows[i].c, rows[i].l1,
                                    rows[i].l2, 0, '0);
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 300 == 0) begin
        drain();
        write_reg(CFG_ACCEPT_BACKFACE, $urandom_range(1));
        write_reg(CFG_DET_MIN, (n == 600) ? 54'd0 : 54'($urandom_range(0, 5000)));
      end
      if (n == 400) begin
        send_idle_pct = 45;
        recv_idle_pct = 23;
      end
      if (n == 800) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 900) hold_req = 1'b1;  // block fills and stalls input
      if ($urandom_range(9) < 8) begin
        // well-formed: line through a point near the triangle (edge weights up to 300/512 each)
        int w0, w1;
        va = rnd_small();
        vb = rnd_small();
        vc = rnd_small();
        w0 = $urandom_range(0, 300);
        w1 = $urandom_range(0, 300);
        l1 = rnd_small();
        for (int k = 0; k < 3; k++)
          l2[k*CW +: CW] = 16'(coord(va,k) + ((coord(vb,k)-coord(va,k))*w0 +
                               (coord(vc,k)-coord(va,k))*w1) / 512);
        if ($urandom_range(1)) begin
          {l1, l2} = {l2, l1};
        end
      end else begin
        va = rnd_word();
        vb = rnd_word();
        vc = rnd_word();
        l1 = rnd_word();
        l2 = rnd_word();
      end
      send_triangle(va, vb, vc, l1, l2, 0, '0);
    end

    drain();
    repeat (6) @(posedge clk);
    if (n_fail == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
